// ===== rtl/core/asc_pkg.sv =====
// ----------------------------------------------------------------------------
// asc_pkg
// Shared types and constants of the auto-ranging seven-segment scanner.
// ----------------------------------------------------------------------------
package asc_pkg;

    localparam int DIGIT_COUNT = 4;
    localparam int POS_W       = 2;
    localparam int VALUE_W     = 25;
    localparam int INTERVAL_W  = 16;
    localparam int NUM_W       = 14;
    localparam int SEG_W       = 8;

    // Configuration port.
    localparam int          ADDR_W            = 3;
    localparam int          DATA_W            = 32;
    localparam logic        REG_SCAN_INTERVAL = 1'b0;
    localparam logic [15:0] INTERVAL_RESET    = 16'd40;
    localparam logic [15:0] TICK_MAX          = 16'hFFFF;

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Ranging thresholds on the magnitude in thousandths.
    localparam logic [VALUE_W-1:0] RANGE0_MAX = 25'd1000;
    localparam logic [VALUE_W-1:0] RANGE1_MAX = 25'd10000;
    localparam logic [VALUE_W-1:0] RANGE2_MAX = 25'd100000;
    localparam logic [NUM_W-1:0]   NUM_MAX    = 14'd9999;

    // Reciprocals for exact truncating division of a 25-bit magnitude.
    localparam int          MAG_SHIFT     = 35;
    localparam logic [35:0] MAG_ONE       = 36'h8_0000_0000;
    localparam logic [31:0] MAG_RECIP_10  = 32'((MAG_ONE + 36'd9) / 36'd10);
    localparam logic [31:0] MAG_RECIP_100 = 32'((MAG_ONE + 36'd99) / 36'd100);
    localparam logic [31:0] MAG_RECIP_1K  = 32'((MAG_ONE + 36'd999) / 36'd1000);

    // Reciprocals for picking a decimal digit out of the shown number.
    localparam int          DIG_SHIFT     = 24;
    localparam logic [24:0] DIG_ONE       = 25'h100_0000;
    localparam logic [20:0] DIG_RECIP_10  = 21'((DIG_ONE + 25'd9) / 25'd10);
    localparam logic [20:0] DIG_RECIP_100 = 21'((DIG_ONE + 25'd99) / 25'd100);
    localparam logic [20:0] DIG_RECIP_1K  = 21'((DIG_ONE + 25'd999) / 25'd1000);
    localparam int          TEN_SHIFT     = 18;
    localparam logic [14:0] TEN_RECIP     = 15'd26215;

    localparam logic [SEG_W-1:0] POINT_SEG = 8'h80;

    typedef struct packed {
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] value;
    } asc_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } asc_qstat_t;

    function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] d);
        logic [SEG_W-1:0] s;
        unique case (d)
            4'd0: s = 8'h3f;
            4'd1: s = 8'h06;
            4'd2: s = 8'h5b;
            4'd3: s = 8'h4f;
            4'd4: s = 8'h66;
            4'd5: s = 8'h6d;
            4'd6: s = 8'h7d;
            4'd7: s = 8'h07;
            4'd8: s = 8'h7f;
            4'd9: s = 8'h6f;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/core/autorange_seven_segment_scanner.sv =====
// ----------------------------------------------------------------------------
// autorange_seven_segment_scanner
// Scans a four-digit seven-segment display with auto-ranged decimal point.
//
// Input stream: s_tuser[0] selects the word kind. A load word (1) stores
// s_tdata[24:0] as a signed value in thousandths and gives no result. A tick
// word (0) advances the tick counter; once scan_interval ticks have passed,
// it produces one result for the current digit and moves to the next digit.
// Result stream: m_tdata[3:0] is the active-low digit enable, m_tdata[11:4]
// the segment byte with the decimal point in bit 7.
// A step enters the four-entry step queue at the edge that accepts its
// tick word and then passes the five registered stages of the conversion
// pipeline. Throughput is one word per cycle while the queue is not full.
// A stalled receiver freezes the conversion pipeline; words are still taken
// until the step queue fills, then s_tready drops.
// Reset clears the stored value, tick counter and digit position and sets
// scan_interval (register at byte address 0) to 40.
// ----------------------------------------------------------------------------
module autorange_seven_segment_scanner (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [asc_pkg::ADDR_W-1:0]  paddr,
    input  logic [asc_pkg::DATA_W-1:0]  pwdata,
    output logic [asc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // [24:0] value_milli
    input  logic [0:0]                  s_tuser,   // [0] command
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata    // [3:0] digit_enable_n, [11:4] segments
);

    asc_pkg::asc_qstat_t qstat;
    asc_pkg::asc_entry_t push_entry;
    asc_pkg::asc_entry_t pop_entry;
    logic                push;
    logic                pop;

    asc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .qstat      (qstat),
        .push       (push),
        .push_entry (push_entry)
    );

    asc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .qstat      (qstat)
    );

    asc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .qstat     (qstat),
        .pop_entry (pop_entry),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== rtl/core/asc_front.sv =====
// ----------------------------------------------------------------------------
// asc_front
// Takes input words and register writes, keeps the shown value and the
// tick counter, and queues one scan step whenever the interval has elapsed.
// ----------------------------------------------------------------------------
module asc_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Register port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [asc_pkg::ADDR_W-1:0]          paddr,
    input  logic [asc_pkg::DATA_W-1:0]          pwdata,
    output logic [asc_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [31:0]                         s_tdata,  // [24:0] value_milli
    input  logic [0:0]                          s_tuser,  // [0] command
    // Queue side.
    input  asc_pkg::asc_qstat_t                 qstat,
    output logic                                push,
    output asc_pkg::asc_entry_t                 push_entry
);

    logic [asc_pkg::INTERVAL_W-1:0] scan_interval_reg;
    logic [asc_pkg::INTERVAL_W-1:0] tick_count_reg;
    logic [asc_pkg::INTERVAL_W-1:0] tick_count_next;
    logic [asc_pkg::VALUE_W-1:0]    shown_value_reg;
    logic [asc_pkg::POS_W-1:0]      scan_position_reg;
    logic                           accept;
    logic                           is_load;
    logic                           cfg_write;
    logic [asc_pkg::INTERVAL_W-1:0] tick_sat;
    logic                           step;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == asc_pkg::REG_SCAN_INTERVAL);
    assign prdata    = (paddr[2] == asc_pkg::REG_SCAN_INTERVAL)
                       ? {16'd0, scan_interval_reg} : '0;

    assign s_tready = !qstat.full;
    assign accept   = s_tvalid && s_tready;
    assign is_load  = s_tuser[0];

    assign tick_sat = (tick_count_reg == asc_pkg::TICK_MAX)
                      ? tick_count_reg : tick_count_reg + 16'd1;
    assign step     = accept && !is_load && (tick_sat >= scan_interval_reg);

    always_comb begin
        tick_count_next = tick_count_reg;
        if (accept && !is_load) begin
            tick_count_next = step ? '0 : tick_sat;
        end
    end

    assign push             = step;
    assign push_entry.pos   = scan_position_reg;
    assign push_entry.value = shown_value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_interval_reg <= asc_pkg::INTERVAL_RESET;
            tick_count_reg    <= '0;
            shown_value_reg   <= '0;
            scan_position_reg <= '0;
        end else begin
            if (cfg_write) begin
                scan_interval_reg <= pwdata[asc_pkg::INTERVAL_W-1:0];
            end
            tick_count_reg <= tick_count_next;
            if (accept && is_load) begin
                shown_value_reg <= s_tdata[asc_pkg::VALUE_W-1:0];
            end
            if (step) begin
                scan_position_reg <= scan_position_reg + 2'd1;
            end
        end
    end

endmodule

// ===== rtl/core/asc_queue.sv =====
// ----------------------------------------------------------------------------
// asc_queue
// Small first-in first-out buffer of scan steps between front and back.
// ----------------------------------------------------------------------------
module asc_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  asc_pkg::asc_entry_t push_entry,
    input  logic                pop,
    output asc_pkg::asc_entry_t pop_entry,
    output asc_pkg::asc_qstat_t qstat
);

    asc_pkg::asc_entry_t             mem [asc_pkg::QUEUE_DEPTH];
    logic [asc_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [asc_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [asc_pkg::QCNT_W-1:0]      count_reg;
    logic [asc_pkg::QCNT_W-1:0]      count_next;

    assign qstat.full  = (count_reg == asc_pkg::QCNT_W'(asc_pkg::QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign pop_entry   = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 3'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !qstat.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !qstat.empty)
        else $error("queue read while empty");

    a_count_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 3'd1))
        else $error("queue count did not follow a write");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg[asc_pkg::QPTR_W-1:0] == wr_ptr_reg - rd_ptr_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

// ===== rtl/core/asc_back.sv =====
// ----------------------------------------------------------------------------
// asc_back
// Pipeline that turns a queued scan step into a digit enable and a segment
// byte: magnitude and range, scaling, digit selection, segment lookup.
// ----------------------------------------------------------------------------
module asc_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  asc_pkg::asc_qstat_t qstat,
    input  asc_pkg::asc_entry_t pop_entry,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata    // [3:0] digit_enable_n, [11:4] segments
);

    logic adv;

    // Stage A: magnitude and range.
    logic                        a_valid_reg;
    logic [asc_pkg::VALUE_W-1:0] a_mag_reg;
    logic [1:0]                  a_point_reg;
    logic                        a_neg_reg;
    logic [asc_pkg::POS_W-1:0]   a_pos_reg;
    logic [asc_pkg::VALUE_W-1:0] mag;
    logic [1:0]                  point;

    // Stage B: scaled product.
    logic                        b_valid_reg;
    logic [21:0]                 b_quot_reg;
    logic [9:0]                  b_small_reg;
    logic [1:0]                  b_point_reg;
    logic                        b_neg_reg;
    logic [asc_pkg::POS_W-1:0]   b_pos_reg;
    logic [31:0]                 mag_recip;
    logic [56:0]                 mag_prod;

    // Stage C: shown number and digit choice.
    logic                        c_valid_reg;
    logic [asc_pkg::NUM_W-1:0]   c_num_reg;
    logic [1:0]                  c_digit_reg;
    logic                        c_sign_reg;
    logic                        c_point_hit_reg;
    logic [asc_pkg::POS_W-1:0]   c_pos_reg;
    logic [asc_pkg::NUM_W-1:0]   num;

    // Stage D: number divided down to the chosen digit.
    logic                        d_valid_reg;
    logic [asc_pkg::NUM_W-1:0]   d_quot_reg;
    logic                        d_sign_reg;
    logic                        d_point_hit_reg;
    logic [asc_pkg::POS_W-1:0]   d_pos_reg;
    logic [20:0]                 dig_recip;
    logic [34:0]                 dig_prod;

    // Output stage.
    logic                        out_valid_reg;
    logic [3:0]                  out_enable_n_reg;
    logic [asc_pkg::SEG_W-1:0]   out_seg_reg;
    logic [28:0]                 ten_prod;
    logic [10:0]                 tens;
    logic [asc_pkg::NUM_W-1:0]   rem_full;
    logic [asc_pkg::SEG_W-1:0]   seg;

    assign adv = !out_valid_reg || m_tready;
    assign pop = adv && !qstat.empty;

    // Stage A logic.
    always_comb begin
        mag = pop_entry.value[asc_pkg::VALUE_W-1]
              ? (~pop_entry.value) + 25'd1 : pop_entry.value;
        priority if (mag <= asc_pkg::RANGE0_MAX) begin
            point = 2'd0;
        end else if (mag <= asc_pkg::RANGE1_MAX) begin
            point = 2'd1;
        end else if (mag <= asc_pkg::RANGE2_MAX) begin
            point = 2'd2;
        end else begin
            point = 2'd3;
        end
    end

    // Stage B logic. The small range needs no division and bypasses it.
    always_comb begin
        unique case (a_point_reg)
            2'd1:    mag_recip = asc_pkg::MAG_RECIP_10;
            2'd2:    mag_recip = asc_pkg::MAG_RECIP_100;
            default: mag_recip = asc_pkg::MAG_RECIP_1K;
        endcase
        mag_prod = {32'd0, a_mag_reg} * {25'd0, mag_recip};
    end

    // Stage C logic.
    always_comb begin
        if (b_point_reg == 2'd0) begin
            num = {4'd0, b_small_reg};
        end else if (b_quot_reg > {8'd0, asc_pkg::NUM_MAX}) begin
            num = asc_pkg::NUM_MAX;
        end else begin
            num = b_quot_reg[asc_pkg::NUM_W-1:0];
        end
    end

    // Stage D logic: digit 0 is thousands, digit 3 is units.
    always_comb begin
        unique case (c_digit_reg)
            2'd0:    dig_recip = asc_pkg::DIG_RECIP_1K;
            2'd1:    dig_recip = asc_pkg::DIG_RECIP_100;
            default: dig_recip = asc_pkg::DIG_RECIP_10;
        endcase
        dig_prod = {21'd0, c_num_reg} * {14'd0, dig_recip};
    end

    // Output logic: the remainder by ten of the divided number is the digit.
    always_comb begin
        ten_prod = {15'd0, d_quot_reg} * {14'd0, asc_pkg::TEN_RECIP};
        tens     = ten_prod[28:asc_pkg::TEN_SHIFT];
        rem_full = d_quot_reg - (({3'd0, tens} << 3) + ({3'd0, tens} << 1));
        seg      = d_sign_reg ? asc_pkg::POINT_SEG : asc_pkg::seg_code(rem_full[3:0]);
        if (d_point_hit_reg) begin
            seg = seg | asc_pkg::POINT_SEG;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg   <= pop;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= c_valid_reg;
            out_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_mag_reg   <= mag;
            a_point_reg <= point;
            a_neg_reg   <= pop_entry.value[asc_pkg::VALUE_W-1];
            a_pos_reg   <= pop_entry.pos;

            b_quot_reg  <= mag_prod[56:asc_pkg::MAG_SHIFT];
            b_small_reg <= a_mag_reg[9:0];
            b_point_reg <= a_point_reg;
            b_neg_reg   <= a_neg_reg;
            b_pos_reg   <= a_pos_reg;

            // A negative value shifts the digits right by one position.
            c_num_reg       <= num;
            c_digit_reg     <= b_neg_reg ? b_pos_reg - 2'd1 : b_pos_reg;
            c_sign_reg      <= b_neg_reg && (b_pos_reg == 2'd0);
            c_point_hit_reg <= (b_pos_reg == b_point_reg);
            c_pos_reg       <= b_pos_reg;

            d_quot_reg      <= (c_digit_reg == 2'd3)
                               ? c_num_reg : {3'd0, dig_prod[34:asc_pkg::DIG_SHIFT]};
            d_sign_reg      <= c_sign_reg;
            d_point_hit_reg <= c_point_hit_reg;
            d_pos_reg       <= c_pos_reg;

            out_enable_n_reg <= ~(4'd1 << d_pos_reg);
            out_seg_reg      <= seg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_seg_reg, out_enable_n_reg};

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Auto-ranging seven-segment scanner testbench
// Drives load and tick words into the stream input and the scan interval
// register over APB, predicts every digit word from its own model of the
// scanner, and checks each accepted digit word in order. Both stream sides
// idle in random bursts, and the receiver stalls long enough once to fill
// the block up.
// ----------------------------------------------------------------------------

typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_LOAD = 1'b1
} command_e;

typedef struct packed {
    logic [3:0] enable_n;
    logic [7:0] segments;
} digit_word_t;

class digit_scoreboard;
    logic [15:0] interval;
    logic [24:0] value;
    logic [1:0]  position;
    logic [15:0] ticks;
    logic [7:0]  seg_table [10];
    digit_word_t expected_digits [$];
    int          errors;

    function new();
        seg_table = '{8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f};
        interval  = asc_pkg::INTERVAL_RESET;
        value     = '0;
        position  = '0;
        ticks     = '0;
        errors    = 0;
    endfunction

    function void set_interval(logic [15:0] v);
        interval = v;
    endfunction

    function logic [7:0] digit_pattern(logic [24:0] raw, logic [1:0] pos);
        logic [24:0] mag;
        logic        neg;
        int unsigned num;
        logic [1:0]  point;
        int unsigned d;
        logic [7:0]  seg;
        neg = raw[24];
        mag = neg ? (~raw + 25'd1) : raw;
        if (mag <= 1000) begin
            num = mag;
            point = 2'd0;
        end else if (mag <= 10000) begin
            num = mag / 10;
            point = 2'd1;
        end else if (mag <= 100000) begin
            num = mag / 100;
            point = 2'd2;
        end else begin
            num = mag / 1000;
            point = 2'd3;
        end
        if (num > 9999) num = 9999;
        if (neg && pos == 2'd0) begin
            // Sign marker: a lone point on the leading digit.
            seg = asc_pkg::POINT_SEG;
        end else begin
            // A negative value shifts the digits one place to the right.
            case (neg ? pos - 2'd1 : pos)
                2'd0: d = num / 1000;
                2'd1: d = (num % 1000) / 100;
                2'd2: d = (num % 100) / 10;
                default: d = num % 10;
            endcase
            seg = seg_table[d];
        end
        if (pos == point) seg |= asc_pkg::POINT_SEG;
        return seg;
    endfunction

    function void note_word(logic cmd, logic [24:0] v);
        digit_word_t w;
        if (cmd == CMD_LOAD) begin
            value = v;
            return;
        end
        if (ticks != asc_pkg::TICK_MAX) ticks++;
        if (ticks < interval) return;
        ticks      = '0;
        w.enable_n = ~(4'b0001 << position);
        w.segments = digit_pattern(value, position);
        expected_digits.push_back(w);
        position++;
    endfunction

    function void check_digit(logic [3:0] en, logic [7:0] seg);
        digit_word_t w;
        if (expected_digits.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected digit word: enable_n=%h segments=%h", en, seg);
            return;
        end
        w = expected_digits.pop_front();
        if (en !== w.enable_n || seg !== w.segments) begin
            errors++;
            if (errors <= 10)
                $display("digit word mismatch: expected enable_n=%h segments=%h, got %h %h",
                         w.enable_n, w.segments, en, seg);
        end
    endfunction

    function void check_register(logic [31:0] exp_val, logic [31:0] act_val);
        if (act_val !== exp_val) begin
            errors++;
            if (errors <= 10)
                $display("scan_interval readback: expected %h, got %h", exp_val, act_val);
        end
    endfunction

    function int pending();
        return expected_digits.size();
    endfunction

    function void close();
        if (expected_digits.size() != 0) begin
            errors++;
            $display("%0d digit words never arrived", expected_digits.size());
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [asc_pkg::ADDR_W-1:0] INTERVAL_ADDR =
        asc_pkg::ADDR_W'(4 * asc_pkg::REG_SCAN_INTERVAL);

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [asc_pkg::ADDR_W-1:0] paddr;
    logic [asc_pkg::DATA_W-1:0] pwdata;
    logic [asc_pkg::DATA_W-1:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [24:0] value_milli
    logic [0:0]  s_tuser;   // [0] command
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [3:0] digit_enable_n, [11:4] segments

    digit_scoreboard sb = new();

    int send_gap_pct;
    int recv_gap_pct;
    bit quiet;
    bit long_hold;

    autorange_seven_segment_scanner u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_word(s_tuser[0], s_tdata[24:0]);
        if (aresetn && m_tvalid && m_tready)
            sb.check_digit(m_tdata[3:0], m_tdata[11:4]);
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        m_tready = 1'b0;
        forever begin
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (300) @(negedge aclk);
                long_hold = 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < recv_gap_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(negedge aclk);
            end
        end
    end

    task automatic send_word(command_e cmd, logic [24:0] v);
        int n;
        if (!quiet && $urandom_range(0, 99) < send_gap_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            n = $urandom_range(1, 15);
            repeat (n - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'b0, v};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop sending and let every expected digit word come out.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_interval(logic [15:0] v);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= INTERVAL_ADDR;
        pwdata  <= {16'b0, v};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_interval(v);
        // Read the register back right away.
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.check_register({16'b0, v}, prdata);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Values cluster on the ranging thresholds and the extremes.
    function automatic logic [24:0] pick_value();
        int v;
        int base;
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 3))
                    0: base = 1000;
                    1: base = 10000;
                    2: base = 100000;
                    default: base = 9999999;
                endcase
                v = base + $urandom_range(0, 4) - 2;
                if ($urandom_range(0, 1) == 1) v = -v;
            end
            1: v = $urandom_range(0, 1) ? 32'hFF00_0000 : 0;
            2: begin
                v = $urandom_range(0, 2000);
                if ($urandom_range(0, 1) == 1) v = -v;
            end
            3: v = $urandom_range(0, 19999998) - 9999999;
            default: v = $urandom();
        endcase
        return v[24:0];
    endfunction

    task automatic run_random(int count);
        repeat (count) begin
            if ($urandom_range(0, 9) < 3)
                send_word(CMD_LOAD, pick_value());
            else
                send_word(CMD_TICK, 25'($urandom()));
        end
    endtask

    initial begin
        logic [24:0] corner_values [8];
        logic [15:0] intervals     [7];
        int          send_gaps     [7];
        corner_values = '{25'd0, 25'd1000, 25'd1001, 25'd10000, 25'd100001,
                          25'd9999999, 25'(-9999999), 25'h1000000};
        intervals = '{16'd1, 16'd0, 16'd3, 16'd2, 16'd0, 16'd6, 16'd1};
        send_gaps = '{25, 0, 40, 10, 0, 60, 15};
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        send_gap_pct = 20;
        recv_gap_pct = 20;
        quiet        = 1'b0;
        long_hold    = 1'b0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // The reset interval should give one step after forty ticks.
        repeat (41) send_word(CMD_TICK, 25'($urandom()));
        drain();

        // Corner values, each followed by two digit steps.
        write_interval(16'd0);
        foreach (corner_values[i]) begin
            send_word(CMD_LOAD, corner_values[i]);
            send_word(CMD_TICK, '0);
            send_word(CMD_TICK, '1);
        end
        drain();

        foreach (intervals[i]) begin
            write_interval(intervals[i]);
            send_gap_pct = send_gaps[i];
            recv_gap_pct = (i % 3 == 2) ? 0 : 25;
            if (i == 1) long_hold = 1'b1;
            run_random(75);
            drain();
        end

        // Widest interval: a few ticks that stay below it, so no step comes.
        write_interval(16'hFFFF);
        send_gap_pct = 0;
        send_word(CMD_LOAD, pick_value());
        repeat (10) send_word(CMD_TICK, 25'($urandom()));
        drain();

        // A lower interval with a count left over, then no idling at all.
        quiet = 1'b1;
        write_interval(16'd4);
        run_random(40);
        drain();

        sb.close();
        if (sb.errors == 0)
            $display("autorange_seven_segment_scanner regression: pass");
        else
            $display("autorange_seven_segment_scanner regression: fail");
        $finish;
    end

    initial begin
        #15_000_000;
        $display("autorange_seven_segment_scanner regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/asc_pkg.sv
rtl/core/asc_front.sv
rtl/core/asc_queue.sv
rtl/core/asc_back.sv
rtl/core/autorange_seven_segment_scanner.sv
sim/testbench.sv
